### sv/pst_pkg.sv
// Shared widths and the sequencer state type of the priority schedule timing core.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

  localparam int ID_W     = 8;
  localparam int TF_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int RES_W    = 21;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 72;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_SCAN = 4'b0010,
    S_CALC = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

`default_nettype wire

### sv/priority_schedule_timing_core.sv
// Top level of the non-preemptive priority scheduler: job store, scan sequencer, result stage.
// Depends on pst_pkg and pst_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Carries
// s_axis    in         s_axis_tvalid / s_axis_tready  one job per item, tlast closes the set
// m_axis    out        m_axis_tvalid / m_axis_tready  one schedule result per item
//
// Loading accepts one job per cycle. Once a set is closed the input is not ready until the
// last result has been produced. Each pick scans the n stored jobs through the single read
// port of the job store, one job a cycle, and scans them a second time when no job is ready
// and time jumps to the earliest pending arrival. Reset is synchronous and clears the
// sequencer, job count, drop flag and done mask; the store itself is never cleared, as only
// written entries are read. A stalled result holds the sequencer in its final step, while
// the next set may already be loaded behind the last.

module priority_schedule_timing_core #(
  parameter int MAX_JOBS   = 16,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] job_id, [23:8] arrival, [39:24] burst, [47:40] priority_level
  input  wire logic [pst_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] out_job_id, [28:8] completion, [49:29] turnaround,
  // [70:50] waiting, [71] zero padding
  output logic      [pst_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // [0] jobs_dropped
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  import pst_pkg::*;

  // Arrival and burst are kept in their low bits only, never more than the field width.
  localparam int AW    = (TIME_WIDTH < TF_W) ? TIME_WIDTH : TF_W;
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  // The clock can reach the largest arrival plus every burst, so it needs CNT_W extra bits.
  localparam int CT_W  = AW + CNT_W;
  localparam int RW    = ID_W + 2 * AW + PRIO_W;

  state_t state;

  logic [CNT_W-1:0]    cnt;
  logic                ovf;
  logic [MAX_JOBS-1:0] done;
  logic [CNT_W-1:0]    pick;
  logic [CNT_W-1:0]    sc;
  logic                vld_d;
  logic [IDX_W-1:0]    idx_d;
  logic                found;
  logic                min_vld;
  logic [AW-1:0]       min_arr;
  logic [CT_W-1:0]     cur;

  logic [IDX_W-1:0]    best_idx;
  logic [ID_W-1:0]     best_id;
  logic [AW-1:0]       best_arr;
  logic [AW-1:0]       best_burst;
  logic [PRIO_W-1:0]   best_prio;
  logic [CT_W-1:0]     comp_r;
  logic [CT_W-1:0]     wait_r;
  logic [CT_W-1:0]     turn;

  logic                in_acc;
  logic                wr_en;
  logic [RW-1:0]       wr_data;
  logic                rd_en;
  logic [RW-1:0]       rd_data;
  logic [ID_W-1:0]     rd_id;
  logic [AW-1:0]       rd_arr;
  logic [AW-1:0]       rd_burst;
  logic [PRIO_W-1:0]   rd_prio;
  logic                pending;
  logic                ready_hit;
  logic                take;
  logic                scan_end;
  logic                slot_free;
  logic                emit;
  logic [CNT_W-1:0]    pick_inc;
  logic                last_pick;

  assign s_axis_tready = (state == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // A job that finds the store full is dropped and only remembered in the flag.
  assign wr_en   = in_acc && (cnt < CNT_W'(MAX_JOBS));
  assign wr_data = {s_axis_tdata[40 +: PRIO_W], s_axis_tdata[24 +: AW],
                    s_axis_tdata[8 +: AW], s_axis_tdata[0 +: ID_W]};

  assign rd_en = (state == S_SCAN) && (sc < cnt);

  pst_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_JOBS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(cnt[IDX_W-1:0]),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(sc[IDX_W-1:0]),
    .rdata(rd_data)
  );

  assign rd_id    = rd_data[0 +: ID_W];
  assign rd_arr   = rd_data[ID_W +: AW];
  assign rd_burst = rd_data[ID_W + AW +: AW];
  assign rd_prio  = rd_data[ID_W + 2 * AW +: PRIO_W];

  // Compare step of the scan: the entry read last cycle against the best so far.
  // Ties on priority go to the earlier arrival, then to the entry scanned first.
  assign pending   = vld_d && !done[idx_d];
  assign ready_hit = pending && (CT_W'(rd_arr) <= cur);
  assign take      = ready_hit &&
                     (!found || (rd_prio < best_prio) ||
                      ((rd_prio == best_prio) && (rd_arr < best_arr)));
  assign scan_end  = (sc == cnt) && !vld_d;

  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign emit      = (state == S_EMIT) && slot_free;
  assign pick_inc  = pick + CNT_W'(1);
  assign last_pick = (pick_inc == cnt);
  assign turn      = comp_r - CT_W'(best_arr);

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      cnt           <= '0;
      ovf           <= 1'b0;
      done          <= '0;
      pick          <= '0;
      sc            <= '0;
      vld_d         <= 1'b0;
      found         <= 1'b0;
      min_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded keeps the valid high.
      if (m_axis_tvalid && m_axis_tready && !emit) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (wr_en) begin
              cnt <= cnt + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_axis_tlast) begin
              state   <= S_SCAN;
              done    <= '0;
              pick    <= '0;
              sc      <= '0;
              vld_d   <= 1'b0;
              found   <= 1'b0;
              min_vld <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          vld_d <= rd_en;
          if (rd_en) begin
            sc <= sc + CNT_W'(1);
          end
          if (take) begin
            found <= 1'b1;
          end
          if (pending) begin
            min_vld <= 1'b1;
          end
          if (scan_end) begin
            if (found) begin
              state <= S_CALC;
            end else begin
              // Nothing has arrived yet: the clock jumps ahead and the scan runs again.
              sc      <= '0;
              min_vld <= 1'b0;
            end
          end
        end
        S_CALC: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            m_axis_tvalid <= 1'b1;
            pick          <= pick_inc;
            if (last_pick) begin
              state <= S_LOAD;
              cnt   <= '0;
              ovf   <= 1'b0;
              done  <= '0;
            end else begin
              state          <= S_SCAN;
              done[best_idx] <= 1'b1;
              sc             <= '0;
              vld_d          <= 1'b0;
              found          <= 1'b0;
              min_vld        <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Datapath registers: the clock, the best candidate, the time arithmetic and the result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (in_acc && s_axis_tlast) begin
          cur <= '0;
        end
      end
      S_SCAN: begin
        idx_d <= sc[IDX_W-1:0];
        if (take) begin
          best_idx   <= idx_d;
          best_id    <= rd_id;
          best_arr   <= rd_arr;
          best_burst <= rd_burst;
          best_prio  <= rd_prio;
        end
        if (pending && (!min_vld || (rd_arr < min_arr))) begin
          min_arr <= rd_arr;
        end
        if (scan_end && !found) begin
          cur <= CT_W'(min_arr);
        end
      end
      S_CALC: begin
        comp_r <= cur + CT_W'(best_burst);
        wait_r <= cur - CT_W'(best_arr);
      end
      S_EMIT: begin
        if (slot_free) begin
          m_axis_tdata <= {1'b0, RES_W'(wait_r), RES_W'(turn), RES_W'(comp_r), best_id};
          m_axis_tuser <= ovf;
          m_axis_tlast <= last_pick;
          cur          <= comp_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/pst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; used by the top level for the job store.
`timescale 1ns / 1ps
`default_nettype none

module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
